/* rtl/core/rsk_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsk_pkg
// shared constants and payload types of the record sort and year filter
// ----------------------------------------------------------------------------
package rsk_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_BYTES_DEF = 30;
    localparam int IN_KEY_BYTES  = 30;
    localparam int IN_KEY_W      = IN_KEY_BYTES * 8;
    localparam int ID_W          = 16;
    localparam int YEAR_W        = 14;
    localparam int SLOT_W        = 4;

    typedef struct packed {
        logic [63:0]       key_bytes_0_7;
        logic [63:0]       key_bytes_8_15;
        logic [63:0]       key_bytes_16_23;
        logic [47:0]       key_bytes_24_29;
        logic [ID_W-1:0]   book_id;
        logic [YEAR_W-1:0] pub_year;
        logic              final_record;
    } t_rec_in;

    typedef struct packed {
        logic [ID_W-1:0]   out_book_id;
        logic [YEAR_W-1:0] out_year;
        logic [SLOT_W-1:0] load_slot;
        logic              run_end;
        logic              none_found;
        logic              overflowed;
    } t_rec_out;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [YEAR_W-1:0] year;
    } t_rec_entry;

endpackage

/* rtl/core/rsk_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsk_if
// valid/ready channels for incoming records and emitted results
// ----------------------------------------------------------------------------
interface rsk_in_if;
    logic             valid;
    logic             ready;
    rsk_pkg::t_rec_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rsk_out_if;
    logic              valid;
    logic              ready;
    rsk_pkg::t_rec_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/record_sort_by_text_key_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_sort_by_text_key_filter
// collects records, exchange-sorts them by text key, emits those at or
// after a configurable year
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  i_rec     in   valid/ready    rsk_pkg::t_rec_in  (one record per transaction)
//  o_res     out  valid/ready    rsk_pkg::t_rec_out (one result per transaction)
//  i_cfg     in   i_cfg_wr_en    i_cfg_wr_data      (min_year, no read-back)
//
//  records load one per cycle in S_LOAD; the record with final_record starts the sort
//  sort: each compared pair steps through S_J_ADDR, S_J_KEY, S_CMP_LOAD and S_CMP,
//    which scans bytes until the first difference or a shared NUL (at most KEY_BYTES);
//    each outer pass adds S_I_START, S_I_WAIT and S_I_END; S_I_START leaves the sort
//  emit: S_E_ADDR, S_E_REC, S_E_CHECK per record, then S_E_FINISH; the output register
//    stalls the emit walk while a result waits, input is not taken until emit ends
//  keys are compared one byte a cycle through two shift registers
//  reset is synchronous, active low; the key, record and order memories need none
// ----------------------------------------------------------------------------
module record_sort_by_text_key_filter #(
    parameter int CAPACITY  = rsk_pkg::CAPACITY_DEF,
    parameter int KEY_BYTES = rsk_pkg::KEY_BYTES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    rsk_in_if.sink                    i_rec,
    rsk_out_if.source                 o_res,
    input  logic                      i_cfg_wr_en,
    input  logic [rsk_pkg::YEAR_W-1:0] i_cfg_wr_data
);
    import rsk_pkg::*;

    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int KW  = KEY_BYTES * 8;
    localparam int KCW = $clog2(KEY_BYTES + 1);

    typedef enum logic [3:0] {
        S_LOAD,
        S_I_START,
        S_I_WAIT,
        S_J_ADDR,
        S_J_KEY,
        S_CMP_LOAD,
        S_CMP,
        S_I_END,
        S_E_ADDR,
        S_E_REC,
        S_E_CHECK,
        S_E_FINISH
    } t_state;

    // memories
    logic [KW-1:0] key_mem  [CAPACITY];
    t_rec_entry    rec_mem  [CAPACITY];
    logic [IW-1:0] perm_mem [CAPACITY];

    // control registers
    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_ovf, n_ovf;
    logic [YEAR_W-1:0] r_min_year, n_min_year;
    logic [CW-1:0]     r_num, n_num;
    logic [CW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_j, n_j;
    logic [CW-1:0]     r_e, n_e;
    logic              r_have, n_have;
    logic              r_out_valid, n_out_valid;

    // payload registers
    logic [IW-1:0]     r_cur, n_cur;
    logic [IW-1:0]     r_other, n_other;
    logic [KCW-1:0]    r_kcnt, n_kcnt;
    logic [KW-1:0]     r_sa, n_sa;
    logic [KW-1:0]     r_sb, n_sb;
    t_rec_out          r_pend, n_pend;
    t_rec_out          r_out, n_out;

    // memory read data
    logic [IW-1:0]     r_perm_q;
    logic [KW-1:0]     r_ka_q, r_kb_q;
    t_rec_entry        r_rec_q;

    // memory controls
    logic              load_we;
    logic              perm_we, perm_re, key_re, rec_re;
    logic [IW-1:0]     perm_waddr, perm_wdata, perm_raddr;

    logic [KW-1:0]       key_word;
    logic [IN_KEY_W-1:0] in_key_flat;
    logic                in_ready;
    logic                out_free;
    logic [7:0]          byte_a, byte_b;
    logic                cmp_done, cmp_gt;
    logic [IW+SLOT_W-1:0] slot_ext;
    t_rec_out            new_res;

    // input key widened or cut to KEY_BYTES, missing bytes read as zero
    assign in_key_flat = {i_rec.data.key_bytes_0_7, i_rec.data.key_bytes_8_15,
                          i_rec.data.key_bytes_16_23, i_rec.data.key_bytes_24_29};

    for (genvar k = 0; k < KEY_BYTES; k++) begin : g_key
        if (k < IN_KEY_BYTES) begin : g_in
            assign key_word[KW-1-8*k -: 8] = in_key_flat[IN_KEY_W-1-8*k -: 8];
        end else begin : g_zero
            assign key_word[KW-1-8*k -: 8] = 8'h00;
        end
    end

    assign in_ready    = (r_state == S_LOAD);
    assign i_rec.ready = in_ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;
    assign out_free    = !r_out_valid || o_res.ready;

    assign byte_a   = r_sa[KW-1 -: 8];
    assign byte_b   = r_sb[KW-1 -: 8];
    assign slot_ext = {{SLOT_W{1'b0}}, r_other};

    // candidate result built from the record just read
    always_comb begin
        new_res             = '0;
        new_res.out_book_id = r_rec_q.id;
        new_res.out_year    = r_rec_q.year;
        new_res.load_slot   = slot_ext[SLOT_W-1:0];
        new_res.overflowed  = r_ovf;
    end

    // byte-serial key compare: first differing byte decides, shared NUL ends equal
    always_comb begin
        cmp_done = 1'b0;
        cmp_gt   = 1'b0;
        if (byte_a != byte_b) begin
            cmp_done = 1'b1;
            cmp_gt   = (byte_a > byte_b);
        end else if (byte_a == 8'h00 || r_kcnt == KCW'(KEY_BYTES - 1)) begin
            cmp_done = 1'b1;
        end
    end

    // next-state logic
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_min_year  = r_min_year;
        n_num       = r_num;
        n_i         = r_i;
        n_j         = r_j;
        n_e         = r_e;
        n_have      = r_have;
        n_out_valid = r_out_valid && !o_res.ready;
        n_cur       = r_cur;
        n_other     = r_other;
        n_kcnt      = r_kcnt;
        n_sa        = r_sa;
        n_sb        = r_sb;
        n_pend      = r_pend;
        n_out       = r_out;

        load_we     = 1'b0;
        perm_we     = 1'b0;
        perm_re     = 1'b0;
        key_re      = 1'b0;
        rec_re      = 1'b0;
        perm_waddr  = r_count[IW-1:0];
        perm_wdata  = r_count[IW-1:0];
        perm_raddr  = r_i[IW-1:0];

        if (i_cfg_wr_en) begin
            n_min_year = i_cfg_wr_data;
        end

        case (r_state)
            S_LOAD: begin
                if (i_rec.valid) begin
                    if (r_count < CW'(CAPACITY)) begin
                        load_we = 1'b1;
                        perm_we = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_rec.data.final_record) begin
                        n_num   = (r_count < CW'(CAPACITY)) ? r_count + CW'(1) : r_count;
                        n_i     = '0;
                        n_state = S_I_START;
                    end
                end
            end
            S_I_START: begin
                if (r_i + CW'(1) >= r_num) begin
                    n_e     = '0;
                    n_state = S_E_ADDR;
                end else begin
                    perm_re    = 1'b1;
                    perm_raddr = r_i[IW-1:0];
                    n_j        = r_i + CW'(1);
                    n_state    = S_I_WAIT;
                end
            end
            S_I_WAIT: begin
                n_cur   = r_perm_q;
                n_state = S_J_ADDR;
            end
            S_J_ADDR: begin
                perm_re    = 1'b1;
                perm_raddr = r_j[IW-1:0];
                n_state    = S_J_KEY;
            end
            S_J_KEY: begin
                key_re  = 1'b1;
                n_other = r_perm_q;
                n_state = S_CMP_LOAD;
            end
            S_CMP_LOAD: begin
                n_sa    = r_ka_q;
                n_sb    = r_kb_q;
                n_kcnt  = '0;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (cmp_done) begin
                    // key at i greater: the two records change places
                    if (cmp_gt) begin
                        perm_we    = 1'b1;
                        perm_waddr = r_j[IW-1:0];
                        perm_wdata = r_cur;
                        n_cur      = r_other;
                    end
                    if (r_j + CW'(1) == r_num) begin
                        n_state = S_I_END;
                    end else begin
                        n_j     = r_j + CW'(1);
                        n_state = S_J_ADDR;
                    end
                end else begin
                    n_sa   = r_sa << 8;
                    n_sb   = r_sb << 8;
                    n_kcnt = r_kcnt + KCW'(1);
                end
            end
            S_I_END: begin
                // position i now holds the smallest of the rest
                perm_we    = 1'b1;
                perm_waddr = r_i[IW-1:0];
                perm_wdata = r_cur;
                n_i        = r_i + CW'(1);
                n_state    = S_I_START;
            end
            S_E_ADDR: begin
                if (r_e == r_num) begin
                    n_state = S_E_FINISH;
                end else begin
                    perm_re    = 1'b1;
                    perm_raddr = r_e[IW-1:0];
                    n_state    = S_E_REC;
                end
            end
            S_E_REC: begin
                rec_re  = 1'b1;
                n_other = r_perm_q;
                n_state = S_E_CHECK;
            end
            S_E_CHECK: begin
                // one qualifying result held back so the last can carry run_end
                if (r_rec_q.year >= r_min_year) begin
                    if (r_have) begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out       = r_pend;
                            n_pend      = new_res;
                            n_e         = r_e + CW'(1);
                            n_state     = S_E_ADDR;
                        end
                    end else begin
                        n_have  = 1'b1;
                        n_pend  = new_res;
                        n_e     = r_e + CW'(1);
                        n_state = S_E_ADDR;
                    end
                end else begin
                    n_e     = r_e + CW'(1);
                    n_state = S_E_ADDR;
                end
            end
            S_E_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_have) begin
                        n_out         = r_pend;
                        n_out.run_end = 1'b1;
                    end else begin
                        n_out            = '0;
                        n_out.run_end    = 1'b1;
                        n_out.none_found = 1'b1;
                        n_out.overflowed = r_ovf;
                    end
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_have  = 1'b0;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_min_year  <= '0;
            r_num       <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_e         <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_min_year  <= n_min_year;
            r_num       <= n_num;
            r_i         <= n_i;
            r_j         <= n_j;
            r_e         <= n_e;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
        r_cur   <= n_cur;
        r_other <= n_other;
        r_kcnt  <= n_kcnt;
        r_sa    <= n_sa;
        r_sb    <= n_sb;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

    // key memory, two registered read ports
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            key_mem[r_count[IW-1:0]] <= key_word;
        end
        if (key_re) begin
            r_ka_q <= key_mem[r_cur];
            r_kb_q <= key_mem[r_perm_q];
        end
    end

    // book number and year memory
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            rec_mem[r_count[IW-1:0]] <= '{id: i_rec.data.book_id, year: i_rec.data.pub_year};
        end
        if (rec_re) begin
            r_rec_q <= rec_mem[r_perm_q];
        end
    end

    // sorted order as load positions
    always_ff @(posedge i_clk) begin
        if (perm_we) begin
            perm_mem[perm_waddr] <= perm_wdata;
        end
        if (perm_re) begin
            r_perm_q <= perm_mem[perm_raddr];
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("record count above capacity");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_j > r_i && r_j < r_num))
        else $error("compare pair out of order");

    a_byte_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_kcnt < KCW'(KEY_BYTES)))
        else $error("key byte counter past key length");

    a_none_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.none_found) |-> r_out.run_end)
        else $error("none_found result without run_end");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_E_FINISH && out_free) |=> (r_count == '0 && !r_ovf && !r_have))
        else $error("set not cleared after emit");
`endif

endmodule
